@@ design/tpled_pkg.sv @@
package tpled_pkg;

	// Field widths.
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned LEVEL_W  = 7;
	localparam int unsigned BRT_W    = 8;
	localparam int unsigned IND_W    = 8;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Item kinds.
	localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_IND    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	// Caps lock position within the HID indicator bits.
	localparam int unsigned CAPS_BIT = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_FLOOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY    = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [LEVEL_W-1:0] RST_LEVEL_MIN    = 7'd10;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_MAX    = 7'd100;
	localparam logic [LEVEL_W-1:0] RST_BREATH_FLOOR = 7'd20;
	localparam logic [LEVEL_W-1:0] RST_BREATH_STEP  = 7'd5;
	localparam logic [TICK_W-1:0]  RST_FRAME_TICKS  = 16'd40;
	localparam logic [TICK_W-1:0]  RST_OFF_DELAY    = 16'd5000;

endpackage

@@ design/tpled_in_if.sv @@
interface tpled_in_if;
	logic                               valid;
	logic                               ready;
	logic [tpled_pkg::FUNC_W-1:0]       func;
	logic                               touched;
	logic                               kb_active;
	logic [tpled_pkg::BRT_W-1:0]        backlight_level;
	logic [tpled_pkg::IND_W-1:0]        indicators;

	modport source (
		output valid, func, touched, kb_active, backlight_level, indicators,
		input  ready
	);
	modport sink (
		input  valid, func, touched, kb_active, backlight_level, indicators,
		output ready
	);
endinterface

@@ design/tpled_out_if.sv @@
interface tpled_out_if;
	logic                               valid;
	logic                               ready;
	logic                               led_write;
	logic [tpled_pkg::LEVEL_W-1:0]      led_level;
	logic [tpled_pkg::LEVEL_W-1:0]      last_valid_level;

	modport source (
		output valid, led_write, led_level, last_valid_level,
		input  ready
	);
	modport sink (
		input  valid, led_write, led_level, last_valid_level,
		output ready
	);
endinterface

@@ design/trackpad_indicator_led_controller.sv @@
// Indicator LED controller for a trackpad with caps lock breathing.
// Input channel in_ch: one beat per item (status sample, HID indicator update
// or one-millisecond tick). Output channel out_ch: exactly one beat per item,
// in order, carrying led_write, led_level and last_valid_level.
// The item is captured in an input register, evaluated against the stored
// state combinationally, and the result lands in an output register.
// Throughput is one item per cycle while the receiver does not stall; the state
// update loop sets it.
// When the receiver stalls, the output register holds its beat and the input
// register fills; in_ch.ready drops only once both are occupied, and it
// rises again in the same cycle the output beat is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// do so only while the block is idle, not enforced here; indexes 6 and 7 are ignored.
// arst_n clears both pipeline registers, restores the configuration defaults
// (min 10, max 100, floor 20, step 5, frame 40 ticks, off delay 5000 ticks)
// and returns the LED state to caps off, untouched, stored level 100.
module trackpad_indicator_led_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpled_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpled_pkg::CFG_DATA_W-1:0]     cfg_data,
	tpled_in_if.sink                             in_ch,
	tpled_out_if.source                          out_ch
);

	typedef struct packed {
		logic [tpled_pkg::LEVEL_W-1:0] level;
		logic                          rising;
	} breath_t;

	// One breathing frame: advance the triangle wave by one step.
	function automatic breath_t breath_next(
		input logic [tpled_pkg::LEVEL_W-1:0] lvl,
		input logic                          up,
		input logic [tpled_pkg::LEVEL_W-1:0] lmax,
		input logic [tpled_pkg::LEVEL_W-1:0] floor_lvl,
		input logic [tpled_pkg::LEVEL_W-1:0] step
	);
		logic [tpled_pkg::LEVEL_W:0] sum;
		logic [tpled_pkg::LEVEL_W:0] lim;
		breath_t                     res;
		sum = {1'b0, lvl} + {1'b0, step};
		lim = {1'b0, floor_lvl} + {1'b0, step};
		if (up) begin
			res.level  = (sum < {1'b0, lmax}) ? sum[tpled_pkg::LEVEL_W-1:0] : lmax;
			res.rising = !(res.level >= lmax);
		end else begin
			res.level  = ({1'b0, lvl} >= lim) ? (lvl - step) : floor_lvl;
			res.rising = (res.level <= floor_lvl);
		end
		return res;
	endfunction

	// Configuration registers.
	logic [tpled_pkg::LEVEL_W-1:0] level_min_q, level_max_q, breath_floor_q, breath_step_q;
	logic [tpled_pkg::TICK_W-1:0]  frame_ticks_q, off_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_min_q    <= tpled_pkg::RST_LEVEL_MIN;
			level_max_q    <= tpled_pkg::RST_LEVEL_MAX;
			breath_floor_q <= tpled_pkg::RST_BREATH_FLOOR;
			breath_step_q  <= tpled_pkg::RST_BREATH_STEP;
			frame_ticks_q  <= tpled_pkg::RST_FRAME_TICKS;
			off_delay_q    <= tpled_pkg::RST_OFF_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				tpled_pkg::REG_LEVEL_MIN:    level_min_q    <= cfg_data[tpled_pkg::LEVEL_W-1:0];
				tpled_pkg::REG_LEVEL_MAX:    level_max_q    <= cfg_data[tpled_pkg::LEVEL_W-1:0];
				tpled_pkg::REG_BREATH_FLOOR: breath_floor_q <= cfg_data[tpled_pkg::LEVEL_W-1:0];
				tpled_pkg::REG_BREATH_STEP:  breath_step_q  <= cfg_data[tpled_pkg::LEVEL_W-1:0];
				tpled_pkg::REG_FRAME_TICKS:  frame_ticks_q  <= cfg_data;
				tpled_pkg::REG_OFF_DELAY:    off_delay_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline handshake: the input register advances whenever the output slot is free.
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				s1_valid_q <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Input register payload.
	logic [tpled_pkg::FUNC_W-1:0] func_s1;
	logic                         touched_s1;
	logic                         kb_active_s1;
	logic [tpled_pkg::BRT_W-1:0]  backlight_s1;
	logic [tpled_pkg::IND_W-1:0]  indicators_s1;

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1       <= in_ch.func;
			touched_s1    <= in_ch.touched;
			kb_active_s1  <= in_ch.kb_active;
			backlight_s1  <= in_ch.backlight_level;
			indicators_s1 <= in_ch.indicators;
		end
	end

	// Controller state.
	logic                          caps_q, touch_q, kb_was_q, rising_q, armed_q;
	logic [tpled_pkg::LEVEL_W-1:0] breath_q, valid_lvl_q;
	logic [tpled_pkg::BRT_W-1:0]   seen_brt_q;
	logic [tpled_pkg::TICK_W-1:0]  frame_cnt_q, off_cnt_q;

	logic                          caps_d, touch_d, kb_was_d, rising_d, armed_d;
	logic [tpled_pkg::LEVEL_W-1:0] breath_d, valid_lvl_d;
	logic [tpled_pkg::BRT_W-1:0]   seen_brt_d;
	logic [tpled_pkg::TICK_W-1:0]  frame_cnt_d, off_cnt_d;
	logic                          wr_d;
	logic [tpled_pkg::LEVEL_W-1:0] wr_lvl_d;

	logic [tpled_pkg::LEVEL_W-1:0] brt_capped;
	logic [tpled_pkg::LEVEL_W-1:0] derived;
	logic                          brt_nz;
	logic                          caps_new;
	breath_t                       frame;

	// Backlight-derived level: clamp to level_max, then raise to level_min.
	always_comb begin
		brt_capped = (backlight_s1 < {1'b0, level_max_q}) ?
			backlight_s1[tpled_pkg::LEVEL_W-1:0] : level_max_q;
		derived    = (brt_capped > level_min_q) ? brt_capped : level_min_q;
		brt_nz     = (backlight_s1 != '0);
		caps_new   = indicators_s1[tpled_pkg::CAPS_BIT];
	end

	// Next-state and result logic for the item in the input register.
	always_comb begin
		caps_d      = caps_q;
		touch_d     = touch_q;
		kb_was_d    = kb_was_q;
		rising_d    = rising_q;
		armed_d     = armed_q;
		breath_d    = breath_q;
		valid_lvl_d = valid_lvl_q;
		seen_brt_d  = seen_brt_q;
		frame_cnt_d = frame_cnt_q;
		off_cnt_d   = off_cnt_q;
		wr_d        = 1'b0;
		wr_lvl_d    = '0;
		frame       = breath_next(breath_q, rising_q, level_max_q, breath_floor_q,
			breath_step_q);

		case (func_s1)
			tpled_pkg::FUNC_STATUS: begin
				// Keyboard activity edge.
				if (kb_active_s1 != kb_was_q) begin
					kb_was_d = kb_active_s1;
					if (kb_active_s1 && brt_nz) begin
						seen_brt_d  = backlight_s1;
						valid_lvl_d = derived;
					end
				end
				// Touch edge while caps lock is off.
				if (!caps_q && (touched_s1 != touch_q)) begin
					touch_d = touched_s1;
					if (touched_s1) begin
						if (kb_was_d && brt_nz) begin
							valid_lvl_d = derived;
						end
						wr_d     = 1'b1;
						wr_lvl_d = (valid_lvl_d < level_max_q) ? valid_lvl_d : level_max_q;
						armed_d  = 1'b0;
					end else begin
						armed_d   = 1'b1;
						off_cnt_d = '0;
					end
				end
				// Backlight change while the keyboard is active.
				if (!caps_q && kb_was_d && (backlight_s1 != seen_brt_d)) begin
					seen_brt_d = backlight_s1;
					if (brt_nz) begin
						valid_lvl_d = derived;
						if (touch_d) begin
							wr_d     = 1'b1;
							wr_lvl_d = (derived < level_max_q) ? derived : level_max_q;
						end
					end
				end
			end
			tpled_pkg::FUNC_IND: begin
				if (caps_new != caps_q) begin
					caps_d = caps_new;
					if (caps_new) begin
						// Breathing restarts at level_min and its first frame is shown now.
						frame = breath_next(level_min_q, 1'b1, level_max_q,
							breath_floor_q, breath_step_q);
						wr_d        = 1'b1;
						wr_lvl_d    = (level_min_q < level_max_q) ? level_min_q : level_max_q;
						breath_d    = frame.level;
						rising_d    = frame.rising;
						armed_d     = 1'b0;
						frame_cnt_d = '0;
					end else begin
						touch_d  = touched_s1;
						wr_d     = 1'b1;
						wr_lvl_d = touched_s1 ?
							((valid_lvl_q < level_max_q) ? valid_lvl_q : level_max_q) : '0;
					end
				end
			end
			tpled_pkg::FUNC_TICK: begin
				// Breathing frame timer.
				if (caps_q) begin
					frame_cnt_d = frame_cnt_q + tpled_pkg::TICK_W'(1);
					if (frame_cnt_d >= frame_ticks_q) begin
						frame_cnt_d = '0;
						wr_d        = 1'b1;
						wr_lvl_d    = (breath_q < level_max_q) ? breath_q : level_max_q;
						breath_d    = frame.level;
						rising_d    = frame.rising;
					end
				end
				// Auto-off timer after release.
				if (armed_q) begin
					off_cnt_d = off_cnt_q + tpled_pkg::TICK_W'(1);
					if (off_cnt_d >= off_delay_q) begin
						armed_d   = 1'b0;
						off_cnt_d = '0;
						if (!caps_q && !touched_s1) begin
							touch_d  = 1'b0;
							wr_d     = 1'b1;
							wr_lvl_d = '0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// State update when the item leaves the input register.
	logic take;
	assign take = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q      <= 1'b0;
			touch_q     <= 1'b0;
			kb_was_q    <= 1'b0;
			rising_q    <= 1'b1;
			armed_q     <= 1'b0;
			breath_q    <= tpled_pkg::RST_LEVEL_MIN;
			valid_lvl_q <= tpled_pkg::RST_LEVEL_MAX;
			seen_brt_q  <= '0;
			frame_cnt_q <= '0;
			off_cnt_q   <= '0;
		end else if (take) begin
			caps_q      <= caps_d;
			touch_q     <= touch_d;
			kb_was_q    <= kb_was_d;
			rising_q    <= rising_d;
			armed_q     <= armed_d;
			breath_q    <= breath_d;
			valid_lvl_q <= valid_lvl_d;
			seen_brt_q  <= seen_brt_d;
			frame_cnt_q <= frame_cnt_d;
			off_cnt_q   <= off_cnt_d;
		end
	end

	// Output register payload.
	logic                          led_write_s2;
	logic [tpled_pkg::LEVEL_W-1:0] led_level_s2, last_valid_s2;

	always_ff @(posedge clk) begin
		if (take) begin
			led_write_s2  <= wr_d;
			led_level_s2  <= wr_lvl_d;
			last_valid_s2 <= valid_lvl_d;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.led_write        = led_write_s2;
	assign out_ch.led_level        = led_level_s2;
	assign out_ch.last_valid_level = last_valid_s2;

`ifndef SYNTHESIS
	// Breathing cancels any pending auto-off, and release cannot arm it while breathing.
	a_caps_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		caps_q |-> !armed_q)
		else $error("auto-off armed while caps lock breathing");

	// A held input beat stays in the input register while the output is stalled.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> (s1_valid_q && $stable(func_s1)
			&& $stable(backlight_s1) && $stable(indicators_s1)))
		else $error("input register changed under stall");

	// The controller state does not move while the result beat is stalled.
	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> ($stable(valid_lvl_q) && $stable(caps_q)
			&& $stable(frame_cnt_q) && $stable(off_cnt_q)))
		else $error("state updated while output stalled");

	// A result beat without an LED write carries level zero.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !led_write_s2) |-> (led_level_s2 == '0))
		else $error("nonzero level without LED write");
`endif

endmodule

@@ tb/sv/trackpad_indicator_led_controller_tb.sv @@
module trackpad_indicator_led_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpled_pkg::*;

	// Function code that the block must ignore.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned PHASES = 9;
	localparam int unsigned ITEMS_PER_PHASE = 140;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic               touched;
		logic               kb;
		logic [BRT_W-1:0]   brt;
		logic [IND_W-1:0]   ind;
	} item_t;

	typedef struct packed {
		logic               wr;
		logic [LEVEL_W-1:0] lvl;
		logic [LEVEL_W-1:0] last_lvl;
	} led_res_t;

	typedef struct {
		item_t    it;
		bit       typed;
		led_res_t want;
	} dir_row_t;

	localparam led_res_t FROM_MODEL = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpled_in_if  in_if ();
	tpled_out_if out_if ();

	trackpad_indicator_led_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// Directed items: func, touched, kb_active, backlight, indicators; then whether the
	// result is typed in here, and the typed result (write, level, stored level).
	dir_row_t dir_rows [22] = '{
		'{'{FUNC_TICK,   1'b0, 1'b0, 8'd0,   8'h00}, 1'b1, '{1'b0, 7'd0,   7'd100}},
		'{'{FUNC_STATUS, 1'b1, 1'b0, 8'd0,   8'h00}, 1'b1, '{1'b1, 7'd100, 7'd100}},
		'{'{FUNC_STATUS, 1'b0, 1'b0, 8'd255, 8'h00}, 1'b1, '{1'b0, 7'd0,   7'd100}},
		'{'{FUNC_UNUSED, 1'b1, 1'b1, 8'd255, 8'hFF}, 1'b1, '{1'b0, 7'd0,   7'd100}},
		'{'{FUNC_STATUS, 1'b0, 1'b1, 8'd255, 8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b1, 1'b1, 8'd1,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b1, 1'b1, 8'd50,  8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b1, 1'b1, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b1, 1'b1, 8'd101, 8'hFF}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b0, 1'b0, 8'd128, 8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_TICK,   1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b1, 1'b0, 8'd0,   8'hFF}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b0, 1'b0, 8'd0,   8'h02}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b0, 1'b1, 8'd77,  8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_TICK,   1'b1, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b1, 1'b1, 8'd255, 8'hFD}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b0, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b0, 1'b0, 8'd0,   8'h02}, 1'b0, FROM_MODEL},
		'{'{FUNC_IND,    1'b0, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b1, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_STATUS, 1'b0, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL},
		'{'{FUNC_TICK,   1'b1, 1'b0, 8'd0,   8'h00}, 1'b0, FROM_MODEL}
	};

	// Register settings of the fixed phases: min, max, floor, step, frame, off delay.
	int unsigned fixed_cfg [5][6] = '{
		'{10,  100, 20,  5,   3,     8},
		'{0,   100, 0,   100, 1,     1},
		'{100, 0,   100, 1,   2,     2},
		'{50,  50,  50,  0,   0,     0},
		'{0,   0,   0,   1,   65535, 65535}
	};

	logic [CFG_IDX_W-1:0] reg_order [6] = '{
		REG_LEVEL_MIN, REG_LEVEL_MAX, REG_BREATH_FLOOR,
		REG_BREATH_STEP, REG_FRAME_TICKS, REG_OFF_DELAY
	};

	// Shadow of the configuration registers.
	logic [LEVEL_W-1:0] cfg_min, cfg_max, cfg_floor, cfg_step;
	logic [TICK_W-1:0]  cfg_frame, cfg_off;

	// Predicted LED state.
	logic               st_caps, st_touch, st_kb, br_rising, off_armed;
	logic [LEVEL_W-1:0] br_level, keep_level;
	logic [BRT_W-1:0]   seen_brt;
	logic [TICK_W-1:0]  frame_cnt, off_cnt;
	logic               led_wr;
	logic [LEVEL_W-1:0] led_lvl;

	led_res_t pending_leds [$];
	bit       drv_typed;
	led_res_t drv_want;
	int       fails;
	bit       gaps_on, stalls_on;
	int       run_left, stall_left;

	// Clock.
	always #6 clk = ~clk;

	function automatic logic [LEVEL_W-1:0] lvl_cap(input int unsigned x);
		return (x < cfg_max) ? x[LEVEL_W-1:0] : cfg_max;
	endfunction

	// Backlight to stored level: clamp to max first, then raise to min.
	function automatic logic [LEVEL_W-1:0] lvl_derive(input logic [BRT_W-1:0] b);
		int unsigned v;
		v = (b < cfg_max) ? b : cfg_max;
		if (v <= cfg_min)
			v = cfg_min;
		return v[LEVEL_W-1:0];
	endfunction

	function automatic void led_set(input int unsigned x);
		led_wr = 1'b1;
		led_lvl = lvl_cap(x);
	endfunction

	// One breathing frame: show the current level, then move the triangle wave.
	function automatic void breath_advance();
		int unsigned bl, fl, st;
		led_set(br_level);
		bl = br_level;
		fl = cfg_floor;
		st = cfg_step;
		if (br_rising) begin
			br_level = lvl_cap(bl + st);
			if (br_level >= cfg_max)
				br_rising = 1'b0;
		end else begin
			br_level = (bl >= fl + st) ? LEVEL_W'(bl - st) : cfg_floor;
			if (br_level <= cfg_floor)
				br_rising = 1'b1;
		end
	endfunction

	function automatic led_res_t led_predict(input item_t it);
		led_res_t r;
		logic     caps_req;
		led_wr = 1'b0;
		led_lvl = '0;
		case (it.func)
			FUNC_STATUS: begin
				if (it.kb != st_kb) begin
					st_kb = it.kb;
					if (it.kb && it.brt != 0) begin
						seen_brt = it.brt;
						keep_level = lvl_derive(it.brt);
					end
				end
				if (!st_caps && it.touched != st_touch) begin
					st_touch = it.touched;
					if (it.touched) begin
						if (st_kb && it.brt != 0)
							keep_level = lvl_derive(it.brt);
						led_set(keep_level);
						off_armed = 1'b0;
					end else begin
						off_armed = 1'b1;
						off_cnt = '0;
					end
				end
				if (!st_caps && st_kb && it.brt != seen_brt) begin
					seen_brt = it.brt;
					if (it.brt != 0) begin
						keep_level = lvl_derive(it.brt);
						if (st_touch)
							led_set(keep_level);
					end
				end
			end
			FUNC_IND: begin
				caps_req = it.ind[CAPS_BIT];
				if (caps_req != st_caps) begin
					st_caps = caps_req;
					if (caps_req) begin
						br_level = cfg_min;
						br_rising = 1'b1;
						off_armed = 1'b0;
						breath_advance();
						frame_cnt = '0;
					end else begin
						st_touch = it.touched;
						led_set(it.touched ? keep_level : 0);
					end
				end
			end
			FUNC_TICK: begin
				if (st_caps) begin
					frame_cnt = frame_cnt + TICK_W'(1);
					if (frame_cnt >= cfg_frame) begin
						frame_cnt = '0;
						breath_advance();
					end
				end
				if (off_armed) begin
					off_cnt = off_cnt + TICK_W'(1);
					if (off_cnt >= cfg_off) begin
						off_armed = 1'b0;
						off_cnt = '0;
						if (!st_caps && !it.touched) begin
							st_touch = 1'b0;
							led_set(0);
						end
					end
				end
			end
			default: ;
		endcase
		r.wr = led_wr;
		r.lvl = led_wr ? led_lvl : '0;
		r.last_lvl = keep_level;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		fails++;
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one beat and hold it until the block takes it.
	task automatic send_item(input item_t it, input bit typed, input led_res_t want);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.func <= it.func;
		in_if.touched <= it.touched;
		in_if.kb_active <= it.kb;
		in_if.backlight_level <= it.brt;
		in_if.indicators <= it.ind;
		drv_typed <= typed;
		drv_want <= want;
		do @(posedge clk); while (!in_if.ready);
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic drain();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (pending_leds.size() != 0);
	endtask

	// Write all six registers on consecutive cycles, with the block idle.
	task automatic set_levels(input int unsigned vals [6]);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= reg_order[i];
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			case (reg_order[i])
				REG_LEVEL_MIN:    cfg_min = vals[i][LEVEL_W-1:0];
				REG_LEVEL_MAX:    cfg_max = vals[i][LEVEL_W-1:0];
				REG_BREATH_FLOOR: cfg_floor = vals[i][LEVEL_W-1:0];
				REG_BREATH_STEP:  cfg_step = vals[i][LEVEL_W-1:0];
				REG_FRAME_TICKS:  cfg_frame = vals[i][TICK_W-1:0];
				REG_OFF_DELAY:    cfg_off = vals[i][TICK_W-1:0];
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: runs of ready, broken by stalls of random length while stalls_on is set.
	always @(posedge clk) begin
		if (run_left > 0) begin
			out_if.ready <= 1'b1;
			run_left--;
		end else if (stall_left > 0) begin
			out_if.ready <= 1'b0;
			stall_left--;
		end else begin
			out_if.ready <= 1'b1;
			run_left = $urandom_range(0, 20);
			if (stalls_on)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	// Predict on every accepted input beat and check every accepted output beat.
	always @(posedge clk) begin : watch
		item_t    it;
		led_res_t res, want;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				it = '{in_if.func, in_if.touched, in_if.kb_active,
					in_if.backlight_level, in_if.indicators};
				res = led_predict(it);
				pending_leds.push_back(drv_typed ? drv_want : res);
			end
			if (out_if.valid && out_if.ready) begin
				if (pending_leds.size() == 0) begin
					report_mismatch("result beat with none pending", out_if.led_level, 0);
				end else begin
					want = pending_leds.pop_front();
					if (out_if.led_write !== want.wr)
						report_mismatch("led_write", out_if.led_write, want.wr);
					if (out_if.led_level !== want.lvl)
						report_mismatch("led_level", out_if.led_level, want.lvl);
					if (out_if.last_valid_level !== want.last_lvl)
						report_mismatch("last_valid_level", out_if.last_valid_level,
							want.last_lvl);
				end
			end
		end
	end

	// Run limit.
	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned vals [6];
		item_t       it;
		int          sent, r;
		bit          finger, kb_on, caps_want;
		logic [BRT_W-1:0] brt_now;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.func = '0;
		in_if.touched = 1'b0;
		in_if.kb_active = 1'b0;
		in_if.backlight_level = '0;
		in_if.indicators = '0;
		out_if.ready = 1'b0;
		drv_typed = 1'b0;
		drv_want = '0;
		fails = 0;
		run_left = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		finger = 1'b0;
		kb_on = 1'b0;
		caps_want = 1'b0;
		brt_now = '0;

		// State after reset.
		cfg_min = RST_LEVEL_MIN;
		cfg_max = RST_LEVEL_MAX;
		cfg_floor = RST_BREATH_FLOOR;
		cfg_step = RST_BREATH_STEP;
		cfg_frame = RST_FRAME_TICKS;
		cfg_off = RST_OFF_DELAY;
		st_caps = 1'b0;
		st_touch = 1'b0;
		st_kb = 1'b0;
		br_rising = 1'b1;
		off_armed = 1'b0;
		br_level = RST_LEVEL_MIN;
		keep_level = RST_LEVEL_MAX;
		seen_brt = '0;
		frame_cnt = '0;
		off_cnt = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration.
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 5) begin
				for (int k = 0; k < 6; k++)
					vals[k] = fixed_cfg[p][k];
			end else begin
				vals[0] = $urandom_range(0, 100);
				vals[1] = $urandom_range(0, 100);
				vals[2] = $urandom_range(0, 100);
				vals[3] = $urandom_range(1, 100);
				vals[4] = $urandom_range(1, 12);
				vals[5] = $urandom_range(1, 30);
			end
			set_levels(vals);
			gaps_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			stalls_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (sent == ITEMS_PER_PHASE / 2)
					drain();
				if ($urandom_range(0, 99) < 12)
					finger = ~finger;
				r = $urandom_range(0, 99);
				it.touched = finger;
				it.kb = 1'($urandom_range(0, 1));
				it.brt = 8'($urandom);
				it.ind = 8'($urandom);
				if (r < 50) begin
					it.func = FUNC_TICK;
				end else if (r < 82) begin
					// Status samples follow a slowly changing keyboard and backlight.
					it.func = FUNC_STATUS;
					if ($urandom_range(0, 99) < 15)
						kb_on = ~kb_on;
					if ($urandom_range(0, 99) < 30) begin
						r = $urandom_range(0, 9);
						brt_now = (r < 2) ? 8'd0 : (r == 2) ? 8'd255 : 8'($urandom);
					end
					it.kb = kb_on;
					it.brt = brt_now;
				end else if (r < 97) begin
					it.func = FUNC_IND;
					if ($urandom_range(0, 1) == 1)
						caps_want = ~caps_want;
					it.ind[CAPS_BIT] = caps_want;
				end else begin
					it.func = FUNC_UNUSED;
				end
				send_item(it, 1'b0, FROM_MODEL);
				if (it.func != FUNC_UNUSED)
					sent++;
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/tpled_pkg.sv
design/tpled_in_if.sv
design/tpled_out_if.sv
design/trackpad_indicator_led_controller.sv
tb/sv/trackpad_indicator_led_controller_tb.sv
